@@ rtl/fspa_pkg.sv @@
// ----------------------------------------------------------------------------
// fspa_pkg
// Shared types, codes and widths of the fixed-slot pool allocator.
// ----------------------------------------------------------------------------
package fspa_pkg;

  localparam int unsigned SLOTS_DEFAULT = 256;

  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned SIZE_W     = 17;
  localparam int unsigned ARENA_W    = 25;
  localparam int unsigned CFG_W      = 32;
  localparam int unsigned SLOT_OUT_W = 8;
  localparam int unsigned USED_W     = 9;
  localparam int unsigned DIV_STEPS  = ARENA_W;

  localparam logic [SIZE_W-1:0]  SIZE_RESET  = SIZE_W'(64);
  localparam logic [ARENA_W-1:0] ARENA_RESET = ARENA_W'(16384);

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_CHECK = 2'd2,
    OP_INIT  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_EMPTY   = 2'd1,
    STATUS_OUTSIDE = 2'd2,
    STATUS_FREE    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CFG_BASE  = 2'd0,
    CFG_SIZE  = 2'd1,
    CFG_ARENA = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic               valid;
    logic [ARENA_W-1:0] dividend;
    logic [SIZE_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [ARENA_W-1:0] quotient;
  } div_rsp_t;

endpackage

@@ rtl/fspa_ram.sv @@
// ----------------------------------------------------------------------------
// fspa_ram
// Simple dual-port synchronous RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module fspa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/fspa_divider.sv @@
// ----------------------------------------------------------------------------
// fspa_divider
// Restoring divider that produces one quotient bit per clock cycle.
// ----------------------------------------------------------------------------
module fspa_divider (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fspa_pkg::div_req_t req_i,
  output fspa_pkg::div_rsp_t rsp_o
);

  localparam int unsigned DW = fspa_pkg::ARENA_W;
  localparam int unsigned VW = fspa_pkg::SIZE_W;
  localparam int unsigned NW = $clog2(fspa_pkg::DIV_STEPS);

  logic          busy_q;
  logic          done_q;
  logic [NW-1:0] cnt_q;
  logic [DW-1:0] dq_q;
  logic [VW-1:0] rem_q;
  logic [VW-1:0] dvs_q;

  logic [VW:0]   rem_sh;
  logic          ge;
  logic [VW:0]   rem_sub;
  logic [VW-1:0] rem_d;
  logic [DW-1:0] dq_d;

  always_comb begin
    rem_sh  = {rem_q, dq_q[DW-1]};
    ge      = (rem_sh >= {1'b0, dvs_q});
    rem_sub = rem_sh - {1'b0, dvs_q};
    rem_d   = ge ? rem_sub[VW-1:0] : rem_sh[VW-1:0];
    dq_d    = {dq_q[DW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.valid) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + NW'(1);
        if (cnt_q == NW'(fspa_pkg::DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid) begin
      dq_q  <= req_i.dividend;
      dvs_q <= req_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      dq_q  <= dq_d;
      rem_q <= rem_d;
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = dq_q;

endmodule

@@ rtl/fixed_slot_pool_allocator_core.sv @@
// ----------------------------------------------------------------------------
// fixed_slot_pool_allocator_core
// Pool of equal-size slots served from a last-in first-out free list.
// ----------------------------------------------------------------------------
// A request is taken when start_i is high and busy_o is low, and its result is
// shown for exactly one cycle with done_o high; the receiver cannot stall it.
// An address check is answered from idle; an allocate reads the free list,
// then forms the block address, or is answered from idle if no slot is free.
// A free runs the 25-step divider that maps the address to a slot and reads
// its in-use flag; it ends with the divider for tail bytes past the last slot,
// and is answered from idle if the address is outside the arena or the slot
// size is zero. An initialize has the divider compute the slot count, then
// one pass writes the free list and clears the in-use memory, one slot a
// cycle. Register writes take effect at the next initialize.
module fixed_slot_pool_allocator_core #(
  parameter int unsigned SLOTS = fspa_pkg::SLOTS_DEFAULT
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [1:0]                         cfg_index_i,
  input  logic [fspa_pkg::CFG_W-1:0]         cfg_wdata_i,
  input  logic                               start_i,
  input  logic [1:0]                         operation_i,
  input  logic [fspa_pkg::ADDR_W-1:0]        address_i,
  output logic                               busy_o,
  output logic                               done_o,
  output logic [1:0]                         status_o,
  output logic [fspa_pkg::ADDR_W-1:0]        block_address_o,
  output logic [fspa_pkg::SLOT_OUT_W-1:0]    slot_number_o,
  output logic                               in_arena_o,
  output logic [fspa_pkg::USED_W-1:0]        used_slots_o,
  output logic [fspa_pkg::ARENA_W-1:0]       used_bytes_o,
  output logic [fspa_pkg::ARENA_W-1:0]       peak_bytes_o
);

  localparam int unsigned SW = $clog2(SLOTS);
  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam int unsigned AW = fspa_pkg::ADDR_W;
  localparam int unsigned ZW = fspa_pkg::SIZE_W;
  localparam int unsigned RW = fspa_pkg::ARENA_W;
  localparam int unsigned PW = SW + ZW;

  typedef enum logic [6:0] {
    S_IDLE      = 7'b0000001,
    S_INIT_DIV  = 7'b0000010,
    S_INIT_FILL = 7'b0000100,
    S_ALLOC_RD  = 7'b0001000,
    S_ALLOC_ADD = 7'b0010000,
    S_FREE_DIV  = 7'b0100000,
    S_FREE_RD   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [AW-1:0] base_q;
  logic [ZW-1:0] size_q;
  logic [RW-1:0] arena_q;
  logic [AW-1:0] lat_base_q;
  logic [ZW-1:0] lat_size_q;
  logic [RW-1:0] lat_arena_q;

  logic [CW-1:0] depth_q;
  logic [CW-1:0] active_q;
  logic [CW-1:0] count_q;
  logic [RW-1:0] total_q;
  logic [RW-1:0] peak_q;
  logic [SW-1:0] fill_q;
  logic [SW-1:0] slot_q;
  logic [PW-1:0] prod_q;

  logic                done_q;
  fspa_pkg::status_e   res_status_q;
  logic [AW-1:0]       res_block_q;
  logic [SW-1:0]       res_slot_q;
  logic                res_flag_q;

  logic                res_load;
  fspa_pkg::status_e   res_status;
  logic [AW-1:0]       res_block;
  logic [SW-1:0]       res_slot;
  logic                res_flag;

  fspa_pkg::op_e       op;
  logic                accept;
  logic [AW-1:0]       offset;
  logic                addr_in_arena;
  logic                free_ok;
  logic                fill_last;
  logic [CW-1:0]       fill_ext;
  logic [CW-1:0]       n_sat;
  logic                q_in_range;
  logic [RW-1:0]       size_ext;

  fspa_pkg::div_req_t  div_req;
  fspa_pkg::div_rsp_t  div_rsp;

  logic          stack_we;
  logic [SW-1:0] stack_waddr;
  logic [SW-1:0] stack_wdata;
  logic          stack_re;
  logic [SW-1:0] stack_raddr;
  logic [SW-1:0] stack_rdata;
  logic          use_we;
  logic [SW-1:0] use_waddr;
  logic          use_wdata;
  logic          use_re;
  logic [SW-1:0] use_raddr;
  logic          use_rdata;

  logic [31:0]   slot_wide;
  logic [31:0]   count_wide;

  assign op            = fspa_pkg::op_e'(operation_i);
  assign busy_o        = (state_q != S_IDLE);
  assign accept        = start_i && !busy_o;
  assign offset        = address_i - lat_base_q;
  assign addr_in_arena = (address_i >= lat_base_q) && (offset < AW'(lat_arena_q));
  assign free_ok       = addr_in_arena && (lat_size_q != '0);
  assign fill_ext      = CW'(fill_q);
  assign fill_last     = (fill_q == SW'(SLOTS - 1));
  assign size_ext      = RW'(lat_size_q);

  always_comb begin
    if (lat_size_q == '0) begin
      n_sat = '0;
    end else if (div_rsp.quotient > RW'(SLOTS)) begin
      n_sat = CW'(SLOTS);
    end else begin
      n_sat = div_rsp.quotient[CW-1:0];
    end
  end

  assign q_in_range = (div_rsp.quotient < RW'(active_q));

  always_comb begin
    div_req.valid    = accept && ((op == fspa_pkg::OP_INIT) ||
                                  ((op == fspa_pkg::OP_FREE) && free_ok));
    div_req.dividend = (op == fspa_pkg::OP_INIT) ? arena_q : offset[RW-1:0];
    div_req.divisor  = (op == fspa_pkg::OP_INIT) ? size_q : lat_size_q;
  end

  fspa_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    stack_we    = 1'b0;
    stack_waddr = depth_q[SW-1:0];
    stack_wdata = slot_q;
    use_we      = 1'b0;
    use_waddr   = slot_q;
    use_wdata   = 1'b0;
    unique case (state_q)
      S_INIT_FILL: begin
        stack_we    = (fill_ext < active_q);
        stack_waddr = fill_q;
        stack_wdata = SW'(active_q - CW'(1) - fill_ext);
        use_we      = 1'b1;
        use_waddr   = fill_q;
      end
      S_ALLOC_RD: begin
        use_we    = 1'b1;
        use_waddr = stack_rdata;
        use_wdata = 1'b1;
      end
      S_FREE_RD: begin
        stack_we = use_rdata && (depth_q < CW'(SLOTS));
        use_we   = use_rdata;
      end
      default: begin
      end
    endcase
  end

  assign stack_re    = accept && (op == fspa_pkg::OP_ALLOC) && (depth_q != '0);
  assign stack_raddr = SW'(depth_q - CW'(1));
  assign use_re      = (state_q == S_FREE_DIV) && div_rsp.done && q_in_range;
  assign use_raddr   = div_rsp.quotient[SW-1:0];

  fspa_ram #(
    .WIDTH (SW),
    .DEPTH (SLOTS)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stack_we),
    .waddr_i (stack_waddr),
    .wdata_i (stack_wdata),
    .re_i    (stack_re),
    .raddr_i (stack_raddr),
    .rdata_o (stack_rdata)
  );

  fspa_ram #(
    .WIDTH (1),
    .DEPTH (SLOTS)
  ) u_use_ram (
    .clk_i   (clk_i),
    .we_i    (use_we),
    .waddr_i (use_waddr),
    .wdata_i (use_wdata),
    .re_i    (use_re),
    .raddr_i (use_raddr),
    .rdata_o (use_rdata)
  );

  always_comb begin
    state_d    = state_q;
    res_load   = 1'b0;
    res_status = fspa_pkg::STATUS_OK;
    res_block  = '0;
    res_slot   = '0;
    res_flag   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (op)
            fspa_pkg::OP_INIT: begin
              state_d = S_INIT_DIV;
            end
            fspa_pkg::OP_ALLOC: begin
              if (depth_q != '0) begin
                state_d = S_ALLOC_RD;
              end else begin
                res_load   = 1'b1;
                res_status = fspa_pkg::STATUS_EMPTY;
              end
            end
            fspa_pkg::OP_FREE: begin
              if (free_ok) begin
                state_d = S_FREE_DIV;
              end else begin
                res_load   = 1'b1;
                res_status = fspa_pkg::STATUS_OUTSIDE;
              end
            end
            default: begin
              res_load = 1'b1;
              res_flag = addr_in_arena;
            end
          endcase
        end
      end
      S_INIT_DIV: begin
        if (div_rsp.done) begin
          state_d = S_INIT_FILL;
        end
      end
      S_INIT_FILL: begin
        if (fill_last) begin
          state_d  = S_IDLE;
          res_load = 1'b1;
        end
      end
      S_ALLOC_RD: begin
        state_d = S_ALLOC_ADD;
      end
      S_ALLOC_ADD: begin
        state_d   = S_IDLE;
        res_load  = 1'b1;
        res_block = lat_base_q + AW'(prod_q);
        res_slot  = slot_q;
      end
      S_FREE_DIV: begin
        if (div_rsp.done) begin
          if (q_in_range) begin
            state_d = S_FREE_RD;
          end else begin
            state_d    = S_IDLE;
            res_load   = 1'b1;
            res_status = fspa_pkg::STATUS_OUTSIDE;
          end
        end
      end
      S_FREE_RD: begin
        state_d    = S_IDLE;
        res_load   = 1'b1;
        res_slot   = slot_q;
        res_status = use_rdata ? fspa_pkg::STATUS_OK : fspa_pkg::STATUS_FREE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      done_q      <= 1'b0;
      base_q      <= '0;
      size_q      <= fspa_pkg::SIZE_RESET;
      arena_q     <= fspa_pkg::ARENA_RESET;
      lat_base_q  <= '0;
      lat_size_q  <= '0;
      lat_arena_q <= '0;
      depth_q     <= '0;
      active_q    <= '0;
      count_q     <= '0;
      total_q     <= '0;
      peak_q      <= '0;
      fill_q      <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= res_load;
      if (cfg_we_i) begin
        case (cfg_index_i)
          fspa_pkg::CFG_BASE:  base_q  <= cfg_wdata_i;
          fspa_pkg::CFG_SIZE:  size_q  <= cfg_wdata_i[ZW-1:0];
          fspa_pkg::CFG_ARENA: arena_q <= cfg_wdata_i[RW-1:0];
          default: begin
          end
        endcase
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept && (op == fspa_pkg::OP_INIT)) begin
            lat_base_q  <= base_q;
            lat_size_q  <= size_q;
            lat_arena_q <= arena_q;
            depth_q     <= '0;
            active_q    <= '0;
            count_q     <= '0;
            total_q     <= '0;
            peak_q      <= '0;
            fill_q      <= '0;
          end else if (stack_re) begin
            depth_q <= depth_q - CW'(1);
          end
        end
        S_INIT_DIV: begin
          if (div_rsp.done) begin
            active_q <= n_sat;
          end
        end
        S_INIT_FILL: begin
          fill_q <= fill_q + SW'(1);
          if (fill_last) begin
            depth_q <= active_q;
          end
        end
        S_ALLOC_RD: begin
          count_q <= count_q + CW'(1);
          total_q <= total_q + size_ext;
        end
        S_ALLOC_ADD: begin
          if (total_q > peak_q) begin
            peak_q <= total_q;
          end
        end
        S_FREE_RD: begin
          if (use_rdata) begin
            if (depth_q < CW'(SLOTS)) begin
              depth_q <= depth_q + CW'(1);
            end
            if (count_q != '0) begin
              count_q <= count_q - CW'(1);
            end
            total_q <= (total_q >= size_ext) ? total_q - size_ext : '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_ALLOC_RD) begin
      slot_q <= stack_rdata;
      prod_q <= PW'(stack_rdata) * PW'(lat_size_q);
    end else if (use_re) begin
      slot_q <= div_rsp.quotient[SW-1:0];
    end
    if (res_load) begin
      res_status_q <= res_status;
      res_block_q  <= res_block;
      res_slot_q   <= res_slot;
      res_flag_q   <= res_flag;
    end
  end

  assign slot_wide  = 32'(res_slot_q);
  assign count_wide = 32'(count_q);

  assign done_o          = done_q;
  assign status_o        = res_status_q;
  assign block_address_o = res_block_q;
  assign slot_number_o   = slot_wide[fspa_pkg::SLOT_OUT_W-1:0];
  assign in_arena_o      = res_flag_q;
  assign used_slots_o    = count_wide[fspa_pkg::USED_W-1:0];
  assign used_bytes_o    = total_q;
  assign peak_bytes_o    = peak_q;

endmodule

@@ rtl/fspa_checker.sv @@
// ----------------------------------------------------------------------------
// fspa_checker
// Port-level checks of the pool allocator, bound to the top level.
// ----------------------------------------------------------------------------
module fspa_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               start_i,
  input logic [1:0]                         operation_i,
  input logic                               busy_o,
  input logic                               done_o,
  input logic [1:0]                         status_o,
  input logic [fspa_pkg::ADDR_W-1:0]        block_address_o,
  input logic [fspa_pkg::ARENA_W-1:0]       used_bytes_o,
  input logic [fspa_pkg::ARENA_W-1:0]       peak_bytes_o
);

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result shown while a request is still in progress");

  a_check_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (operation_i == fspa_pkg::OP_CHECK)) |=> done_o)
    else $error("address check did not answer in the next cycle");

  a_fail_no_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != fspa_pkg::STATUS_OK)) |-> (block_address_o == '0))
    else $error("failed request returned a block address");

  a_peak_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (used_bytes_o <= peak_bytes_o))
    else $error("used bytes exceed peak bytes");

endmodule

bind fixed_slot_pool_allocator_core fspa_checker u_fspa_checker (.*);

@@ test/fixed_slot_pool_allocator_core_tb.sv @@
// ----------------------------------------------------------------------------
// fixed_slot_pool_allocator_core_tb
// Self-checking testbench of the fixed-slot pool allocator. A model of the
// free list, the in-use flags and the usage counters predicts every result.
// Directed requests cover the empty pool before initialization, wrapping
// block addresses, zero and 65536-byte slot sizes, tail bytes, double frees
// and late register changes. Random phases follow with new pool settings,
// mostly alloc and free of live slots, with bursty request pacing.
// ----------------------------------------------------------------------------
module fixed_slot_pool_allocator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned POOL_SLOTS      = fspa_pkg::SLOTS_DEFAULT;
  localparam int unsigned TARGET_REQUESTS = 650;
  localparam int unsigned RUN_LIMIT       = 500000;
  localparam int unsigned END_DRAIN       = POOL_SLOTS + 60;
  localparam int unsigned MAX_PRINTED     = 100;
  localparam logic [1:0]  CFG_UNUSED      = 2'd3;

  typedef struct packed {
    fspa_pkg::status_e                 status;
    logic [fspa_pkg::ADDR_W-1:0]       block;
    logic [fspa_pkg::SLOT_OUT_W-1:0]   slot;
    logic                              in_arena;
    logic [fspa_pkg::USED_W-1:0]       used_slots;
    logic [fspa_pkg::ARENA_W-1:0]      used_bytes;
    logic [fspa_pkg::ARENA_W-1:0]      peak_bytes;
  } pool_result_t;

  logic                              clk_i;
  logic                              rst_ni;
  logic                              cfg_we_i;
  logic [1:0]                        cfg_index_i;
  logic [fspa_pkg::CFG_W-1:0]        cfg_wdata_i;
  logic                              start_i;
  logic [1:0]                        operation_i;
  logic [fspa_pkg::ADDR_W-1:0]       address_i;
  logic                              busy_o;
  logic                              done_o;
  logic [1:0]                        status_o;
  logic [fspa_pkg::ADDR_W-1:0]       block_address_o;
  logic [fspa_pkg::SLOT_OUT_W-1:0]   slot_number_o;
  logic                              in_arena_o;
  logic [fspa_pkg::USED_W-1:0]       used_slots_o;
  logic [fspa_pkg::ARENA_W-1:0]      used_bytes_o;
  logic [fspa_pkg::ARENA_W-1:0]      peak_bytes_o;

  fixed_slot_pool_allocator_core #(
    .SLOTS(POOL_SLOTS)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .start_i        (start_i),
    .operation_i    (operation_i),
    .address_i      (address_i),
    .busy_o         (busy_o),
    .done_o         (done_o),
    .status_o       (status_o),
    .block_address_o(block_address_o),
    .slot_number_o  (slot_number_o),
    .in_arena_o     (in_arena_o),
    .used_slots_o   (used_slots_o),
    .used_bytes_o   (used_bytes_o),
    .peak_bytes_o   (peak_bytes_o)
  );

  logic [31:0]     reg_base;
  int unsigned     reg_size;
  int unsigned     reg_arena;

  logic [31:0]     pool_base;
  int unsigned     pool_size;
  int unsigned     pool_arena;
  int unsigned     pool_slots;
  logic [7:0]      free_list [POOL_SLOTS];
  int unsigned     free_depth;
  logic [POOL_SLOTS-1:0] slot_busy;
  int unsigned     alloc_count;
  int unsigned     alloc_bytes;
  int unsigned     alloc_peak;
  int unsigned     live_slots [$];

  pool_result_t    pending_results [$];
  pool_result_t    want;
  int unsigned     mismatches = 0;
  int unsigned     requests_sent;
  int unsigned     cycle_count = 0;
  logic            bursty;
  int              burst_left;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= RUN_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_val);
    mismatches++;
    if (mismatches <= MAX_PRINTED) begin
      $display("ERROR cycle %0d: %s got 0x%0h expected 0x%0h", cycle_count, what, got,
               exp_val);
    end
  endtask

  function automatic pool_result_t predict_pool_op(fspa_pkg::op_e op, logic [31:0] addr);
    pool_result_t r;
    logic [31:0]  off;
    logic         in_range;
    int unsigned  n;
    int unsigned  s;
    r = '0;
    off = addr - pool_base;
    in_range = (addr >= pool_base) && (off < pool_arena);
    case (op)
      fspa_pkg::OP_INIT: begin
        pool_base = reg_base;
        pool_size = reg_size;
        pool_arena = reg_arena;
        n = (pool_size != 0) ? pool_arena / pool_size : 0;
        if (n > POOL_SLOTS) n = POOL_SLOTS;
        pool_slots = n;
        for (int i = 0; i < n; i++) free_list[i] = 8'(n - 1 - i);
        free_depth = n;
        slot_busy = '0;
        alloc_count = 0;
        alloc_bytes = 0;
        alloc_peak = 0;
        live_slots.delete();
      end
      fspa_pkg::OP_ALLOC: begin
        if (free_depth == 0) begin
          r.status = fspa_pkg::STATUS_EMPTY;
        end else begin
          free_depth--;
          s = 32'(free_list[free_depth]);
          slot_busy[s] = 1'b1;
          alloc_count++;
          alloc_bytes += pool_size;
          if (alloc_bytes > alloc_peak) alloc_peak = alloc_bytes;
          r.block = pool_base + s * pool_size;
          r.slot = 8'(s);
          live_slots.push_back(s);
        end
      end
      fspa_pkg::OP_FREE: begin
        if (!in_range || pool_size == 0) begin
          r.status = fspa_pkg::STATUS_OUTSIDE;
        end else begin
          s = off / pool_size;
          if (s >= pool_slots) begin
            r.status = fspa_pkg::STATUS_OUTSIDE;
          end else if (!slot_busy[s]) begin
            r.status = fspa_pkg::STATUS_FREE;
            r.slot = 8'(s);
          end else begin
            r.slot = 8'(s);
            slot_busy[s] = 1'b0;
            if (free_depth < POOL_SLOTS) begin
              free_list[free_depth] = 8'(s);
              free_depth++;
            end
            if (alloc_count > 0) alloc_count--;
            alloc_bytes = (alloc_bytes >= pool_size) ? alloc_bytes - pool_size : 0;
            for (int i = 0; i < live_slots.size(); i++) begin
              if (live_slots[i] == s) begin
                live_slots.delete(i);
                break;
              end
            end
          end
        end
      end
      default: r.in_arena = in_range;
    endcase
    r.used_slots = fspa_pkg::USED_W'(alloc_count);
    r.used_bytes = fspa_pkg::ARENA_W'(alloc_bytes);
    r.peak_bytes = fspa_pkg::ARENA_W'(alloc_peak);
    return r;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request pending", 32'(status_o), 32'd0);
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.status)
          report_mismatch("status", 32'(status_o), 32'(want.status));
        if (block_address_o !== want.block)
          report_mismatch("block_address", block_address_o, want.block);
        if (slot_number_o !== want.slot)
          report_mismatch("slot_number", 32'(slot_number_o), 32'(want.slot));
        if (in_arena_o !== want.in_arena)
          report_mismatch("in_arena", 32'(in_arena_o), 32'(want.in_arena));
        if (used_slots_o !== want.used_slots)
          report_mismatch("used_slots", 32'(used_slots_o), 32'(want.used_slots));
        if (used_bytes_o !== want.used_bytes)
          report_mismatch("used_bytes", 32'(used_bytes_o), 32'(want.used_bytes));
        if (peak_bytes_o !== want.peak_bytes)
          report_mismatch("peak_bytes", 32'(peak_bytes_o), 32'(want.peak_bytes));
      end
    end
  end

  task automatic idle_cycles(int unsigned n);
    if (n != 0) begin
      @(negedge clk_i) start_i <= 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  task automatic send_request(fspa_pkg::op_e op, logic [31:0] addr);
    @(negedge clk_i);
    start_i <= 1'b1;
    operation_i <= op;
    address_i <= addr;
    do @(posedge clk_i); while (busy_o);
    pending_results.push_back(predict_pool_op(op, addr));
    requests_sent++;
    if (bursty) begin
      burst_left--;
      if (burst_left <= 0) begin
        idle_cycles(($urandom_range(0, 3) == 0) ? $urandom_range(10, 40) :
                    $urandom_range(1, 6));
        burst_left = $urandom_range(1, 16);
      end
    end
  endtask

  task automatic wait_idle();
    if (start_i) @(negedge clk_i) start_i <= 1'b0;
    while (pending_results.size() != 0 || busy_o) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    case (idx)
      fspa_pkg::CFG_BASE:  reg_base = data;
      fspa_pkg::CFG_SIZE:  reg_size = 32'(data[fspa_pkg::SIZE_W-1:0]);
      fspa_pkg::CFG_ARENA: reg_arena = 32'(data[fspa_pkg::ARENA_W-1:0]);
      default: ;
    endcase
    @(negedge clk_i) cfg_we_i <= 1'b0;
  endtask

  function automatic logic [31:0] pick_address();
    logic [31:0] a;
    case ($urandom_range(0, 5))
      0: a = $urandom;
      1: a = pool_base + $urandom_range(0, pool_arena);
      2: a = pool_base + pool_arena - 1;
      3: a = pool_base + pool_arena;
      4: a = pool_base - $urandom_range(1, 16);
      default: a = pool_base + pool_arena - $urandom_range(0, pool_size);
    endcase
    return a;
  endfunction

  task automatic pick_pool_config();
    int unsigned size;
    int unsigned want_slots;
    int unsigned arena;
    logic [31:0] data;
    case ($urandom_range(0, 9))
      0: size = 0;
      1: size = 65536;
      2: size = $urandom_range(1, 131071);
      3: size = 1;
      default: size = $urandom_range(1, 256);
    endcase
    case ($urandom_range(0, 5))
      0: want_slots = $urandom_range(257, 400);
      1: want_slots = 0;
      default: want_slots = $urandom_range(1, 40);
    endcase
    arena = (size == 0) ? $urandom_range(0, 33554431) :
            want_slots * size + $urandom_range(0, size);
    if ($urandom_range(0, 4) != 0) begin
      data = $urandom_range(0, 1) ? $urandom : 32'd0;
      data[fspa_pkg::SIZE_W-1:0] = size[fspa_pkg::SIZE_W-1:0];
      write_reg(fspa_pkg::CFG_SIZE, data);
    end
    if ($urandom_range(0, 4) != 0) begin
      data = $urandom_range(0, 1) ? $urandom : 32'd0;
      data[fspa_pkg::ARENA_W-1:0] = arena[fspa_pkg::ARENA_W-1:0];
      write_reg(fspa_pkg::CFG_ARENA, data);
    end
    if ($urandom_range(0, 4) != 0) begin
      case ($urandom_range(0, 3))
        0: data = 32'd0;
        1: data = 32'hFFFF_FFFF - $urandom_range(0, 32'(arena[fspa_pkg::ARENA_W-1:0]));
        default: data = $urandom;
      endcase
      write_reg(fspa_pkg::CFG_BASE, data);
    end
  endtask

  task automatic random_request();
    int unsigned r;
    int unsigned s;
    r = $urandom_range(0, 99);
    if (r < 38) begin
      send_request(fspa_pkg::OP_ALLOC, $urandom);
    end else if (r < 66 && live_slots.size() != 0) begin
      s = live_slots[$urandom_range(0, live_slots.size() - 1)];
      send_request(fspa_pkg::OP_FREE,
                   pool_base + s * pool_size + $urandom_range(0, pool_size - 1));
    end else if (r < 74 && pool_slots != 0) begin
      s = $urandom_range(0, pool_slots - 1);
      send_request(fspa_pkg::OP_FREE, pool_base + s * pool_size);
    end else if (r < 86) begin
      send_request(fspa_pkg::OP_FREE, pick_address());
    end else if (r < 98) begin
      send_request(fspa_pkg::OP_CHECK, pick_address());
    end else begin
      send_request(fspa_pkg::OP_INIT, $urandom);
    end
  endtask

  task automatic test_before_init();
    bursty = 1'b0;
    send_request(fspa_pkg::OP_ALLOC, 32'd0);
    send_request(fspa_pkg::OP_FREE, 32'd0);
    send_request(fspa_pkg::OP_CHECK, 32'd0);
  endtask

  task automatic test_default_pool();
    bursty = 1'b1;
    burst_left = 3;
    send_request(fspa_pkg::OP_INIT, 32'hFFFF_FFFF);
    send_request(fspa_pkg::OP_ALLOC, 32'hFFFF_FFFF);
    send_request(fspa_pkg::OP_ALLOC, 32'd0);
    send_request(fspa_pkg::OP_FREE, 32'd69);
    send_request(fspa_pkg::OP_FREE, 32'd64);
    send_request(fspa_pkg::OP_CHECK, 32'd16383);
    send_request(fspa_pkg::OP_CHECK, 32'd16384);
    send_request(fspa_pkg::OP_FREE, 32'd0);
    wait_idle();
  endtask

  task automatic test_wrap_and_zero_size();
    bursty = 1'b0;
    write_reg(fspa_pkg::CFG_BASE, 32'hFFFF_FFF0);
    write_reg(fspa_pkg::CFG_SIZE, 32'd16);
    write_reg(fspa_pkg::CFG_ARENA, 32'd40);
    send_request(fspa_pkg::OP_INIT, 32'd0);
    send_request(fspa_pkg::OP_ALLOC, 32'd0);
    send_request(fspa_pkg::OP_ALLOC, 32'd0);
    send_request(fspa_pkg::OP_ALLOC, 32'd0);
    send_request(fspa_pkg::OP_CHECK, 32'hFFFF_FFFF);
    send_request(fspa_pkg::OP_CHECK, 32'h0000_0005);
    send_request(fspa_pkg::OP_FREE, 32'h0000_0003);
    wait_idle();
    write_reg(fspa_pkg::CFG_SIZE, 32'd0);
    send_request(fspa_pkg::OP_FREE, 32'hFFFF_FFF4);
    send_request(fspa_pkg::OP_INIT, 32'd0);
    send_request(fspa_pkg::OP_ALLOC, 32'd0);
    send_request(fspa_pkg::OP_FREE, 32'hFFFF_FFF0);
    wait_idle();
  endtask

  task automatic test_largest_pool_and_tail();
    bursty = 1'b0;
    write_reg(fspa_pkg::CFG_BASE, 32'd0);
    write_reg(fspa_pkg::CFG_SIZE, 32'd65536);
    write_reg(fspa_pkg::CFG_ARENA, 32'd16777216);
    send_request(fspa_pkg::OP_INIT, 32'd0);
    send_request(fspa_pkg::OP_ALLOC, 32'd0);
    send_request(fspa_pkg::OP_CHECK, 32'd16777215);
    wait_idle();
    write_reg(fspa_pkg::CFG_BASE, 32'd1000);
    write_reg(fspa_pkg::CFG_SIZE, 32'd100);
    write_reg(fspa_pkg::CFG_ARENA, 32'd1050);
    write_reg(CFG_UNUSED, $urandom);
    send_request(fspa_pkg::OP_INIT, 32'd0);
    send_request(fspa_pkg::OP_FREE, 32'd2020);
    send_request(fspa_pkg::OP_FREE, 32'd1500);
    send_request(fspa_pkg::OP_CHECK, 32'd999);
    wait_idle();
  endtask

  task automatic test_random_traffic();
    int unsigned phase_len;
    while (requests_sent < TARGET_REQUESTS) begin
      wait_idle();
      pick_pool_config();
      bursty = ($urandom_range(0, 3) != 0);
      burst_left = $urandom_range(1, 16);
      send_request(fspa_pkg::OP_INIT, $urandom);
      phase_len = $urandom_range(40, 100);
      repeat (phase_len) random_request();
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = fspa_pkg::CFG_BASE;
    cfg_wdata_i = '0;
    start_i = 1'b0;
    operation_i = fspa_pkg::OP_ALLOC;
    address_i = '0;
    requests_sent = 0;
    bursty = 1'b0;
    burst_left = 1;
    reg_base = '0;
    reg_size = 32'(fspa_pkg::SIZE_RESET);
    reg_arena = 32'(fspa_pkg::ARENA_RESET);
    pool_base = '0;
    pool_size = 0;
    pool_arena = 0;
    pool_slots = 0;
    free_depth = 0;
    slot_busy = '0;
    alloc_count = 0;
    alloc_bytes = 0;
    alloc_peak = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    test_before_init();
    test_default_pool();
    test_wrap_and_zero_size();
    test_largest_pool_and_tail();
    test_random_traffic();

    wait_idle();
    repeat (END_DRAIN) @(posedge clk_i);
    if (pending_results.size() != 0)
      report_mismatch("results missing at end", 32'd0, 32'(pending_results.size()));
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
